/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCWP_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rcwp assertion failed");

// next-cycle implication, disabled in reset
`define RCWP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rcwp assertion failed");

`endif

/* design/rcwp_pkg.sv */
package rcwp_pkg;

  // configuration register map
  localparam logic [1:0]  ADDR_TEX_WIDTH  = 2'd0;
  localparam logic [10:0] TEX_WIDTH_RESET = 11'd64;
  localparam logic [10:0] TEX_WIDTH_MAX   = 11'd1024;
  localparam logic [10:0] TEX_WIDTH_MIN   = 11'd1;

  // carried alongside the distance divider
  typedef struct packed {
    logic               negative;
    logic               dir_zero;
    logic               door;
    logic               mirror;
    logic signed [31:0] other_dir;
    logic [23:0]        other_base;
  } div1_side_t;

  // carried alongside the texture column unit
  typedef struct packed {
    logic signed [31:0] wall_dist;
    logic               invalid;
    logic [32:0]        divisor;
  } tex_side_t;

  // carried alongside the height divider
  typedef struct packed {
    logic signed [31:0] wall_dist;
    logic               invalid;
    logic [9:0]         texel;
  } div2_side_t;

endpackage

/* design/rcwp_pipe_div.sv */
module rcwp_pipe_div #(
  parameter int DIVW  = 32,
  parameter int HW    = 31,
  parameter int NSTEP = 33,
  parameter int SBW   = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [HW-1:0]    in_hi,
  input  logic [NSTEP-1:0] in_lo,
  input  logic [DIVW-1:0]  in_div,
  input  logic [SBW-1:0]   in_side,
  output logic             out_valid,
  output logic             out_ovf,
  output logic [NSTEP-1:0] out_quot,
  output logic [SBW-1:0]   out_side
);

  localparam int CW = (HW > DIVW) ? HW : DIVW;

  logic             v_r    [0:NSTEP];
  logic             ovf_r  [0:NSTEP];
  logic [NSTEP-1:0] q_r    [0:NSTEP];
  logic [SBW-1:0]   side_r [0:NSTEP];
  logic [DIVW-1:0]  rem_r  [0:NSTEP-1];
  logic [NSTEP-1:0] lo_r   [0:NSTEP-1];
  logic [DIVW-1:0]  div_r  [0:NSTEP-1];

  // entry stage: quotient overflow check on the high part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= DIVW'(in_hi);
      lo_r[0]   <= in_lo;
      div_r[0]  <= in_div;
      q_r[0]    <= '0;
      ovf_r[0]  <= CW'(in_hi) >= CW'(in_div);
      side_r[0] <= in_side;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [DIVW:0] trial;
    logic [DIVW:0] diff;
    logic          ge;

    assign trial = {rem_r[k], lo_r[k][NSTEP-1]};
    assign diff  = trial - {1'b0, div_r[k]};
    assign ge    = trial >= {1'b0, div_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[k+1]    <= {q_r[k][NSTEP-2:0], ge};
        ovf_r[k+1]  <= ovf_r[k];
        side_r[k+1] <= side_r[k];
      end
    end

    if (k + 1 < NSTEP) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k+1] <= ge ? diff[DIVW-1:0] : trial[DIVW-1:0];
          lo_r[k+1]  <= lo_r[k] << 1;
          div_r[k+1] <= div_r[k];
        end
      end
    end
  end

  assign out_valid = v_r[NSTEP];
  assign out_ovf   = ovf_r[NSTEP];
  assign out_quot  = q_r[NSTEP];
  assign out_side  = side_r[NSTEP];

endmodule

/* design/rcwp_texel.sv */
module rcwp_texel #(
  parameter int F   = 16,
  parameter int SBW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [31:0] in_dist,
  input  logic signed [31:0] in_dir,
  input  logic [23:0]        in_base,
  input  logic               in_mirror,
  input  logic               in_zero,
  input  logic [10:0]        in_width,
  input  logic [SBW-1:0]     in_side,
  output logic               out_valid,
  output logic [9:0]         out_texel,
  output logic [SBW-1:0]     out_side
);

  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  logic [F-1:0]       s1_pb_r, s1_base_r;
  logic               s1_mirror_r, s1_zero_r, s2_mirror_r, s2_zero_r;
  logic [SBW-1:0]     s1_side_r, s2_side_r, s3_side_r;
  logic [F+10:0]      s2_scaled_r;
  logic [9:0]         s3_texel_r;
  logic signed [63:0] prod;
  logic [F-1:0]       frac;
  logic [10:0]        tcol;
  logic [10:0]        tsel;

  assign prod = 64'(in_dist) * 64'(in_dir);
  assign frac = s1_base_r + s1_pb_r;
  assign tcol = s2_scaled_r[F+10:F];
  assign tsel = s2_mirror_r ? (in_width - tcol - 11'd1) : tcol;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // hit offset product, fraction scaled by width, then mirror
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pb_r     <= prod[2*F-1:F];
      s1_base_r   <= in_base[F-1:0];
      s1_mirror_r <= in_mirror;
      s1_zero_r   <= in_zero;
      s1_side_r   <= in_side;
      s2_scaled_r <= (F+11)'(frac) * (F+11)'(in_width);
      s2_mirror_r <= s1_mirror_r;
      s2_zero_r   <= s1_zero_r;
      s2_side_r   <= s1_side_r;
      s3_texel_r  <= s2_zero_r ? 10'd0 : tsel[9:0];
      s3_side_r   <= s2_side_r;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_texel = s3_texel_r;
  assign out_side  = s3_side_r;

endmodule

/* design/raycast_wall_column_projection.sv */
// wall column projection for a grid raycaster
// input channel (in_*): one ray hit per transaction, accepted when in_valid
// is high and in_stall is low; the block takes a new column every cycle that in_stall is low.
// output channel (out_*): one result per input, in order, held while
// out_stall is high.
// the pipeline is one setup stage, a 34-stage distance divider (an overflow
// check, then one quotient bit per stage), one saturation stage, a 3-stage
// texture column unit (multiplier, width scale, mirror), a 17-stage height
// divider and the output register. throughput is one column per cycle while
// the output is not stalled, set by the one-step-per-stage dividers.
// a stalled result freezes the whole pipeline; in_stall goes high while the
// output register holds a result that is not taken.
// texture_width sits on the cfg_ port at byte address 0; write it only when
// the pipeline is empty.
// reset empties the pipeline and sets texture_width to 64.
`include "assert_macros.svh"

module raycast_wall_column_projection #(
  parameter int SCREEN_HEIGHT = 512,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_cell_x,
  input  logic [7:0]         in_cell_y,
  input  logic               in_step_x_negative,
  input  logic               in_step_y_negative,
  input  logic               in_hit_side,
  input  logic signed [31:0] in_direction_x,
  input  logic signed [31:0] in_direction_y,
  input  logic [23:0]        in_viewer_x,
  input  logic [23:0]        in_viewer_y,
  input  logic               in_is_door,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_wall_distance,
  output logic [15:0]        out_proj_height,
  output logic [11:0]        out_first_row,
  output logic [11:0]        out_last_row,
  output logic [9:0]         out_texel_column,
  output logic               out_distance_invalid,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int F    = FRACTION_BITS;
  localparam int UNW  = (F + 9 > 24) ? F + 9 : 24;
  localparam int NUMW = UNW + 2;
  localparam int EPS  = (2 ** F + 500) / 1000;
  localparam int HALF = SCREEN_HEIGHT / 2;
  localparam logic [63:0] HEIGHT_DIVIDEND = 64'(SCREEN_HEIGHT) << F;
  localparam int D1SW = $bits(rcwp_pkg::div1_side_t);
  localparam int TXSW = $bits(rcwp_pkg::tex_side_t);
  localparam int D2SW = $bits(rcwp_pkg::div2_side_t);

  logic adv;

  // configuration register
  logic [10:0] tex_width_r;
  logic [10:0] tex_w;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(tex_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r <= rcwp_pkg::TEX_WIDTH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == rcwp_pkg::ADDR_TEX_WIDTH) begin
      tex_width_r <= cfg_pwdata[10:0];
    end
  end

  always_comb begin
    if (tex_width_r < rcwp_pkg::TEX_WIDTH_MIN) begin
      tex_w = rcwp_pkg::TEX_WIDTH_MIN;
    end else if (tex_width_r > rcwp_pkg::TEX_WIDTH_MAX) begin
      tex_w = rcwp_pkg::TEX_WIDTH_MAX;
    end else begin
      tex_w = tex_width_r;
    end
  end

  // whole pipeline moves unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // setup: axis select, numerator and magnitudes
  logic [7:0]             cell_sel;
  logic                   neg_sel;
  logic [23:0]            viewer_sel;
  logic signed [31:0]     dir_sel;
  logic signed [NUMW-1:0] num;
  logic [UNW-1:0]         un;
  logic [31:0]            ud;
  logic [63:0]            dividend1;
  rcwp_pkg::div1_side_t   f_side;

  always_comb begin
    cell_sel   = in_hit_side ? in_cell_y : in_cell_x;
    neg_sel    = in_hit_side ? in_step_y_negative : in_step_x_negative;
    viewer_sel = in_hit_side ? in_viewer_y : in_viewer_x;
    dir_sel    = in_hit_side ? in_direction_y : in_direction_x;
    num        = $signed(((NUMW'(cell_sel) + NUMW'(neg_sel)) << F) - NUMW'(viewer_sel));
    un         = num[NUMW-1] ? UNW'(-num) : UNW'(num);
    ud         = dir_sel[31] ? 32'(-dir_sel) : 32'(dir_sel);
    dividend1  = 64'(un) << F;
    f_side.negative   = num[NUMW-1] != dir_sel[31];
    f_side.dir_zero   = dir_sel == 32'sd0;
    f_side.door       = in_is_door;
    f_side.mirror     = (!in_hit_side && !in_direction_x[31] && in_direction_x != 32'sd0)
                        || (in_hit_side && in_direction_y[31]);
    f_side.other_dir  = in_hit_side ? in_direction_x : in_direction_y;
    f_side.other_base = in_hit_side ? in_viewer_x : in_viewer_y;
  end

  logic                 f_valid_r;
  logic [30:0]          f_hi_r;
  logic [32:0]          f_lo_r;
  logic [31:0]          f_ud_r;
  rcwp_pkg::div1_side_t f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (adv) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_hi_r   <= dividend1[63:33];
      f_lo_r   <= dividend1[32:0];
      f_ud_r   <= ud;
      f_side_r <= f_side;
    end
  end

  // distance divider
  logic                 d1_valid, d1_ovf;
  logic [32:0]          d1_quot;
  logic [D1SW-1:0]      d1_side_vec;
  rcwp_pkg::div1_side_t d1_side;

  rcwp_pipe_div #(.DIVW(32), .HW(31), .NSTEP(33), .SBW(D1SW)) u_div_dist (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(f_valid_r), .in_hi(f_hi_r), .in_lo(f_lo_r), .in_div(f_ud_r),
    .in_side(f_side_r),
    .out_valid(d1_valid), .out_ovf(d1_ovf), .out_quot(d1_quot), .out_side(d1_side_vec)
  );

  assign d1_side = rcwp_pkg::div1_side_t'(d1_side_vec);

  // sign, saturation and height divisor
  logic [32:0]        q_lim, q_sat;
  logic signed [31:0] dist_sat;

  always_comb begin
    q_lim = d1_side.negative ? 33'h080000000 : 33'h07FFFFFFF;
    q_sat = (d1_ovf || d1_quot > q_lim) ? q_lim : d1_quot;
    if (d1_side.dir_zero) begin
      dist_sat = '0;
    end else if (d1_side.negative) begin
      dist_sat = $signed(32'(33'd0 - q_sat));
    end else begin
      dist_sat = $signed(q_sat[31:0]);
    end
  end

  logic               p_valid_r, p_invalid_r, p_mirror_r;
  logic signed [31:0] p_dist_r, p_dir_r;
  logic [23:0]        p_base_r;
  logic [32:0]        p_divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_dist_r    <= dist_sat;
      p_invalid_r <= dist_sat <= 32'sd0;
      p_divisor_r <= 33'(unsigned'(dist_sat)) + (d1_side.door ? 33'(EPS) : 33'd0);
      p_dir_r     <= d1_side.other_dir;
      p_base_r    <= d1_side.other_base;
      p_mirror_r  <= d1_side.mirror;
    end
  end

  // texture column
  rcwp_pkg::tex_side_t t_side_in, t_side;
  logic                t_valid;
  logic [9:0]          t_texel;
  logic [TXSW-1:0]     t_side_vec;

  assign t_side_in.wall_dist = p_dist_r;
  assign t_side_in.invalid   = p_invalid_r;
  assign t_side_in.divisor   = p_divisor_r;

  rcwp_texel #(.F(F), .SBW(TXSW)) u_texel (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(p_valid_r), .in_dist(p_dist_r), .in_dir(p_dir_r), .in_base(p_base_r),
    .in_mirror(p_mirror_r), .in_zero(p_invalid_r), .in_width(tex_w),
    .in_side(t_side_in),
    .out_valid(t_valid), .out_texel(t_texel), .out_side(t_side_vec)
  );

  assign t_side = rcwp_pkg::tex_side_t'(t_side_vec);

  // height divider
  rcwp_pkg::div2_side_t d2_side_in, d2_side;
  logic                 d2_valid, d2_ovf;
  logic [15:0]          d2_quot;
  logic [D2SW-1:0]      d2_side_vec;

  assign d2_side_in.wall_dist = t_side.wall_dist;
  assign d2_side_in.invalid   = t_side.invalid;
  assign d2_side_in.texel     = t_texel;

  rcwp_pipe_div #(.DIVW(33), .HW(48), .NSTEP(16), .SBW(D2SW)) u_div_height (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(t_valid), .in_hi(HEIGHT_DIVIDEND[63:16]), .in_lo(HEIGHT_DIVIDEND[15:0]),
    .in_div(t_side.divisor), .in_side(d2_side_in),
    .out_valid(d2_valid), .out_ovf(d2_ovf), .out_quot(d2_quot), .out_side(d2_side_vec)
  );

  assign d2_side = rcwp_pkg::div2_side_t'(d2_side_vec);

  // line height and clamped rows
  logic [15:0] lh;
  logic [16:0] lh_half, first_w, last_w;

  always_comb begin
    if (d2_side.invalid) begin
      lh = '0;
    end else if (d2_ovf) begin
      lh = 16'hFFFF;
    end else begin
      lh = d2_quot;
    end
    lh_half = 17'(lh >> 1);
    first_w = (lh_half > 17'(HALF)) ? 17'd0 : 17'(HALF) - lh_half;
    last_w  = 17'(HALF) + lh_half;
    if (last_w > 17'(SCREEN_HEIGHT - 1)) begin
      last_w = 17'(SCREEN_HEIGHT - 1);
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_wall_distance    <= d2_side.wall_dist;
      out_proj_height      <= lh;
      out_first_row        <= first_w[11:0];
      out_last_row         <= last_w[11:0];
      out_texel_column     <= d2_side.invalid ? 10'd0 : d2_side.texel;
      out_distance_invalid <= d2_side.invalid;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `RCWP_ASSERT_NOW(a_invalid_no_height, clk, rst_n,
    out_valid && out_distance_invalid, out_proj_height == 16'd0)
  `RCWP_ASSERT_NOW(a_valid_dist_positive, clk, rst_n,
    out_valid && !out_distance_invalid, out_wall_distance > 32'sd0)
  `RCWP_ASSERT_NOW(a_rows_ordered, clk, rst_n,
    out_valid, out_first_row <= out_last_row)
  `RCWP_ASSERT_NEXT(a_stage_frozen, clk, rst_n,
    !adv, $stable(p_dist_r) && $stable(p_divisor_r))

endmodule
